FILE: rtl/text_console_writer_macros.svh
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared concurrent assertion forms for the console checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, skipped while reset is high
`define TCW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("text console writer: same-cycle check failed");

// Next-cycle implication, skipped while reset is high
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("text console writer: next-cycle check failed");

`endif

FILE: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and fixed constants shared by the text console writer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   // Cursor widths cover the largest supported screen
   localparam int COL_W     = 7;
   localparam int ROW_W     = 6;
   localparam int OUT_ROW_W = 5;
   localparam int CSR_IDX_W = 1;

   // Operation codes on the request word
   localparam logic [2:0] OP_PUT      = 3'd0;
   localparam logic [2:0] OP_MOVE_ABS = 3'd1;
   localparam logic [2:0] OP_MOVE_REL = 3'd2;
   localparam logic [2:0] OP_CLEAR    = 3'd3;
   localparam logic [2:0] OP_READ     = 3'd4;

   // Character and attribute constants
   localparam logic [7:0] NEWLINE_CODE = 8'h0A;
   localparam logic [7:0] BLANK_CHAR   = 8'h20;
   localparam logic [7:0] RESET_ATTR   = 8'h07;

   // Control register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_ATTR  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_OFF = 1'b1;

   // Command kinds after classification
   typedef enum logic [2:0] {
      CMD_PUT,
      CMD_NEWLINE,
      CMD_MOVE_ABS,
      CMD_MOVE_REL,
      CMD_CLEAR,
      CMD_READ,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      logic [7:0] text_attribute;
      logic       scroll_off;
   } cfg_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [7:0]        char_code;
      logic signed [7:0] col_value;
      logic signed [5:0] row_value;
      logic [COL_W-1:0]  abs_col;
      logic [ROW_W-1:0]  abs_row;
   } cmd_type;

   typedef struct packed {
      logic [COL_W-1:0]     cursor_col;
      logic [OUT_ROW_W-1:0] cursor_row;
      logic [7:0]           cell_char;
      logic [7:0]           cell_attr;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell console over a COLS x ROWS store of char/attribute cells.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Word
// req_      in         push / full            operation, char, col, row
// rsp_      out        pop / empty            cursor col/row, cell char/attr
// csr_      in         csr_valid / csr_ready  register index, write data
//
// After reset the store is blanked, with full held high.
// A result word passes through the command queue, the engine and the result queue before it can be popped.
// Put, move and unused codes finish in the idle state; read adds a state for the registered store read.
// Newline blanks the rest of the row and clear blanks the whole store through the fill walk.
// A scroll copies each cell one row up and blanks the bottom row, bound by the single store write port.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic [2:0]                      req_operation,
   input  logic [7:0]                      req_char_code,
   input  logic signed [7:0]               req_col_value,
   input  logic signed [5:0]               req_row_value,
   input  logic                            pop,
   output logic                            empty,
   output logic [6:0]                      rsp_cursor_col,
   output logic [4:0]                      rsp_cursor_row,
   output logic [7:0]                      rsp_cell_char,
   output logic [7:0]                      rsp_cell_attr,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [7:0]                      csr_wdata
);

   import tcw_pkg::*;

   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 2;

   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type cmd_wr, cmd_rd;
   logic    rsp_push, rsp_full, rsp_empty;
   rsp_type rsp_wr, rsp_rd;
   logic    init_busy;
   cfg_type cfg;

   logic [7:0] text_attr_ff;
   logic       scroll_off_ff;

   // Control registers, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_attr_ff  <= RESET_ATTR;
         scroll_off_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TEXT_ATTR:  text_attr_ff  <= csr_wdata;
            CSR_SCROLL_OFF: scroll_off_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign cfg.text_attribute = text_attr_ff;
   assign cfg.scroll_off     = scroll_off_ff;

   tcw_front #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_front (
      .push          (push),
      .full          (full),
      .req_operation (req_operation),
      .req_char_code (req_char_code),
      .req_col_value (req_col_value),
      .req_row_value (req_row_value),
      .cmd_full      (cmd_full),
      .init_busy     (init_busy),
      .cmd_push      (cmd_push),
      .cmd           (cmd_wr)
   );

   tcw_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .din   (cmd_wr),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .dout  (cmd_rd),
      .empty (cmd_empty)
   );

   tcw_back #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (!cmd_empty),
      .cmd       (cmd_rd),
      .cmd_pop   (cmd_pop),
      .rsp_space (!rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_wr),
      .init_busy (init_busy)
   );

   tcw_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .din   (rsp_wr),
      .full  (rsp_full),
      .pop   (pop),
      .dout  (rsp_rd),
      .empty (rsp_empty)
   );

   // Result ports
   assign empty          = rsp_empty;
   assign rsp_cursor_col = rsp_rd.cursor_col;
   assign rsp_cursor_row = rsp_rd.cursor_row;
   assign rsp_cell_char  = rsp_rd.cell_char;
   assign rsp_cell_attr  = rsp_rd.cell_attr;

endmodule

`default_nettype wire

FILE: rtl/tcw_fifo.sv
// ----------------------------------------------------------------------------
// tcw_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [AW:0]      wr_ptr_ff, wr_ptr_in;
   logic [AW:0]      rd_ptr_ff, rd_ptr_in;
   logic             do_push, do_pop;

   // Full when pointers differ only in the wrap bit
   assign empty   = (wr_ptr_ff == rd_ptr_ff);
   assign full    = (wr_ptr_ff[AW] != rd_ptr_ff[AW]) &&
                    (wr_ptr_ff[AW-1:0] == rd_ptr_ff[AW-1:0]);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = entry_ff[rd_ptr_ff[AW-1:0]];

   // Advance pointers
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + (AW+1)'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + (AW+1)'(1) : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff[AW-1:0]] <= din;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Request intake: decode the operation and clamp absolute coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic              push,
   output logic              full,
   input  logic [2:0]        req_operation,
   input  logic [7:0]        req_char_code,
   input  logic signed [7:0] req_col_value,
   input  logic signed [5:0] req_row_value,
   input  logic              cmd_full,
   input  logic              init_busy,
   output logic              cmd_push,
   output tcw_pkg::cmd_type  cmd
);

   import tcw_pkg::*;

   localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLS - 1);
   localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROWS - 1);

   // Hold off requests while the queue is full or the screen is being blanked
   assign full     = cmd_full || init_busy;
   assign cmd_push = push && !full;

   // Classify the operation
   always_comb begin
      cmd.char_code = req_char_code;
      cmd.col_value = req_col_value;
      cmd.row_value = req_row_value;
      case (req_operation)
         OP_PUT: begin
            cmd.kind = (req_char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_PUT;
         end
         OP_MOVE_ABS: cmd.kind = CMD_MOVE_ABS;
         OP_MOVE_REL: cmd.kind = CMD_MOVE_REL;
         OP_CLEAR:    cmd.kind = CMD_CLEAR;
         OP_READ:     cmd.kind = CMD_READ;
         default:     cmd.kind = CMD_NOP;
      endcase

      // Saturate the absolute column and row to the screen
      if (req_col_value[7]) begin
         cmd.abs_col = '0;
      end else if (req_col_value[6:0] > COL_MAX) begin
         cmd.abs_col = COL_MAX;
      end else begin
         cmd.abs_col = req_col_value[6:0];
      end
      if (req_row_value[5]) begin
         cmd.abs_row = '0;
      end else if ({1'b0, req_row_value[4:0]} > ROW_MAX) begin
         cmd.abs_row = ROW_MAX;
      end else begin
         cmd.abs_row = {1'b0, req_row_value[4:0]};
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Execution engine: cursor, screen store and the fill, scroll and read walks.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic             clock,
   input  logic             reset,
   input  tcw_pkg::cfg_type cfg,
   input  logic             cmd_valid,
   input  tcw_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  logic             rsp_space,
   output logic             rsp_push,
   output tcw_pkg::rsp_type rsp,
   output logic             init_busy
);

   import tcw_pkg::*;

   localparam int TOTAL = COLS * ROWS;
   localparam int AW    = $clog2(TOTAL);
   localparam int CW    = AW + 1;

   localparam logic [CW-1:0]    LAST_ADDR   = CW'(TOTAL - 1);
   localparam logic [CW-1:0]    END_ADDR    = CW'(TOTAL);
   localparam logic [CW-1:0]    ROW_LEN     = CW'(COLS);
   localparam logic [CW-1:0]    ROW_TAIL    = CW'(COLS - 1);
   localparam logic [CW-1:0]    BOTTOM_BASE = CW'((ROWS - 1) * COLS);
   localparam logic [COL_W-1:0] COL_MAX     = COL_W'(COLS - 1);
   localparam logic [ROW_W-1:0] ROW_MAX     = ROW_W'(ROWS - 1);
   localparam logic [15:0]      RESET_CELL  = {RESET_ATTR, BLANK_CHAR};

   typedef enum logic [4:0] {
      ST_INIT   = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_FILL   = 5'b00100,
      ST_SCROLL = 5'b01000,
      ST_READ   = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CW-1:0]    ptr_ff, ptr_in;
   logic [CW-1:0]    end_ff, end_in;
   logic [CW-1:0]    wptr_ff, wptr_in;
   logic             copy_v_ff, copy_v_in;
   logic             adv_ff, adv_in;

   logic [15:0]      screen_mem [TOTAL];
   logic [15:0]      rd_data_ff;
   logic             mem_we, mem_re;
   logic [AW-1:0]    mem_wa, mem_ra;
   logic [15:0]      mem_wd;

   logic [CW-1:0]    row_base, cur_addr, cmd_addr;
   logic signed [8:0] col_sum;
   logic signed [7:0] row_sum;
   logic [COL_W-1:0] rel_col;
   logic [ROW_W-1:0] rel_row;
   logic             do_adv, finish;

   // Cell addresses for the cursor and for a read request
   assign row_base = CW'(row_ff) * ROW_LEN;
   assign cur_addr = row_base + CW'(col_ff);
   assign cmd_addr = CW'(cmd.abs_row) * ROW_LEN + CW'(cmd.abs_col);

   // Relative move with saturation at both ends
   assign col_sum = $signed({2'b00, col_ff}) + $signed({cmd.col_value[7], cmd.col_value});
   assign row_sum = $signed({2'b00, row_ff}) +
                    $signed({{2{cmd.row_value[5]}}, cmd.row_value});

   always_comb begin
      if (col_sum < 0) begin
         rel_col = '0;
      end else if (col_sum > $signed({2'b00, COL_MAX})) begin
         rel_col = COL_MAX;
      end else begin
         rel_col = col_sum[COL_W-1:0];
      end
      if (row_sum < 0) begin
         rel_row = '0;
      end else if (row_sum > $signed({2'b00, ROW_MAX})) begin
         rel_row = ROW_MAX;
      end else begin
         rel_row = row_sum[ROW_W-1:0];
      end
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      ptr_in    = ptr_ff;
      end_in    = end_ff;
      wptr_in   = wptr_ff;
      copy_v_in = 1'b0;
      adv_in    = adv_ff;
      cmd_pop   = 1'b0;
      finish    = 1'b0;
      do_adv    = 1'b0;
      mem_we    = 1'b0;
      mem_wa    = ptr_ff[AW-1:0];
      mem_wd    = {cfg.text_attribute, BLANK_CHAR};
      mem_re    = 1'b0;
      mem_ra    = ptr_ff[AW-1:0];

      case (state_ff)
         // Blank the whole store after reset
         ST_INIT: begin
            mem_we = 1'b1;
            mem_wd = RESET_CELL;
            if (ptr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + CW'(1);
            end
         end

         // Take one command once a result slot is free
         ST_IDLE: begin
            if (cmd_valid && rsp_space) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  CMD_PUT: begin
                     mem_we = 1'b1;
                     mem_wa = cur_addr[AW-1:0];
                     mem_wd = {cfg.text_attribute, cmd.char_code};
                     if (col_ff == COL_MAX) begin
                        do_adv = 1'b1;
                     end else begin
                        col_in = col_ff + COL_W'(1);
                        finish = 1'b1;
                     end
                  end
                  CMD_NEWLINE: begin
                     ptr_in   = cur_addr;
                     end_in   = row_base + ROW_TAIL;
                     adv_in   = 1'b1;
                     state_in = ST_FILL;
                  end
                  CMD_MOVE_ABS: begin
                     col_in = cmd.abs_col;
                     row_in = cmd.abs_row;
                     finish = 1'b1;
                  end
                  CMD_MOVE_REL: begin
                     col_in = rel_col;
                     row_in = rel_row;
                     finish = 1'b1;
                  end
                  CMD_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     ptr_in   = '0;
                     end_in   = LAST_ADDR;
                     adv_in   = 1'b0;
                     state_in = ST_FILL;
                  end
                  CMD_READ: begin
                     mem_re   = 1'b1;
                     mem_ra   = cmd_addr[AW-1:0];
                     state_in = ST_READ;
                  end
                  default: finish = 1'b1;
               endcase
            end
         end

         // Write blanks from ptr up to end, then advance the row if asked
         ST_FILL: begin
            mem_we = 1'b1;
            if (ptr_ff == end_ff) begin
               state_in = ST_IDLE;
               if (adv_ff) begin
                  do_adv = 1'b1;
               end else begin
                  finish = 1'b1;
               end
            end else begin
               ptr_in = ptr_ff + CW'(1);
            end
         end

         // Copy each cell one row up: read ahead, write the read word in the following cycle
         ST_SCROLL: begin
            if (ptr_ff != END_ADDR) begin
               mem_re    = 1'b1;
               ptr_in    = ptr_ff + CW'(1);
               copy_v_in = 1'b1;
            end
            if (copy_v_ff) begin
               mem_we  = 1'b1;
               mem_wa  = wptr_ff[AW-1:0];
               mem_wd  = rd_data_ff;
               wptr_in = wptr_ff + CW'(1);
            end
            if ((ptr_ff == END_ADDR) && !copy_v_ff) begin
               ptr_in   = BOTTOM_BASE;
               end_in   = LAST_ADDR;
               adv_in   = 1'b0;
               state_in = ST_FILL;
            end
         end

         // Read data is registered now
         ST_READ: begin
            finish   = 1'b1;
            state_in = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase

      // Row advance: wrap, scroll or return to the top
      if (do_adv) begin
         col_in = '0;
         if (row_ff != ROW_MAX) begin
            row_in   = row_ff + ROW_W'(1);
            finish   = 1'b1;
            state_in = ST_IDLE;
         end else if (cfg.scroll_off) begin
            row_in   = '0;
            finish   = 1'b1;
            state_in = ST_IDLE;
         end else begin
            ptr_in   = ROW_LEN;
            wptr_in  = '0;
            adv_in   = 1'b0;
            state_in = ST_SCROLL;
         end
      end
   end

   // Result word
   assign rsp_push       = finish;
   assign rsp.cursor_col = col_in;
   assign rsp.cursor_row = row_in[OUT_ROW_W-1:0];
   assign rsp.cell_char  = (state_ff == ST_READ) ? rd_data_ff[7:0]  : 8'h00;
   assign rsp.cell_attr  = (state_ff == ST_READ) ? rd_data_ff[15:8] : 8'h00;
   assign init_busy      = (state_ff == ST_INIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_INIT;
         col_ff    <= '0;
         row_ff    <= '0;
         ptr_ff    <= '0;
         end_ff    <= '0;
         wptr_ff   <= '0;
         copy_v_ff <= 1'b0;
         adv_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         ptr_ff    <= ptr_in;
         end_ff    <= end_in;
         wptr_ff   <= wptr_in;
         copy_v_ff <= copy_v_in;
         adv_ff    <= adv_in;
      end
   end

   // Screen store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= screen_mem[mem_ra];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks on the console: reset blanking, word count, cursor range.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_console_writer_macros.svh"

module tcw_checker #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input logic       clock,
   input logic       reset,
   input logic       push,
   input logic       full,
   input logic       pop,
   input logic       empty,
   input logic [6:0] rsp_cursor_col,
   input logic [4:0] rsp_cursor_row
);

   localparam logic [6:0] COL_MAX  = 7'(COLS - 1);
   localparam logic [4:0] ROW_MAX  = 5'(ROWS - 1);
   localparam logic       ROW_FITS = (ROWS <= 32);

   logic [3:0] pending_ff, pending_in;
   logic       in_take, out_take;

   // Count words accepted but not yet popped
   assign in_take  = push && !full;
   assign out_take = pop && !empty;

   always_comb begin
      pending_in = pending_ff;
      if (in_take && !out_take) begin
         pending_in = pending_ff + 4'd1;
      end else if (out_take && !in_take) begin
         pending_in = pending_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // Requests are held off while the store is blanked after reset
   `TCW_ASSERT_NOW(a_init_holds_off, clock, reset, $past(reset), full)
   // No result word without an accepted request behind it
   `TCW_ASSERT_NOW(a_no_spurious_word, clock, reset, pending_ff == 4'd0, empty)
   // Reported cursor stays on the screen
   `TCW_ASSERT_NOW(a_cursor_in_range, clock, reset, !empty,
      (rsp_cursor_col <= COL_MAX) && (!ROW_FITS || (rsp_cursor_row <= ROW_MAX)))
   // A waiting result word is not dropped
   `TCW_ASSERT_NEXT(a_word_kept, clock, reset, !empty && !pop, !empty)

endmodule

bind text_console_writer tcw_checker #(
   .COLS (COLS),
   .ROWS (ROWS)
) u_tcw_checker (
   .clock          (clock),
   .reset          (reset),
   .push           (push),
   .full           (full),
   .pop            (pop),
   .empty          (empty),
   .rsp_cursor_col (rsp_cursor_col),
   .rsp_cursor_row (rsp_cursor_row)
);

`default_nettype wire

FILE: bench/text_console_writer_checker.sv
// ----------------------------------------------------------------------------
// text_console_writer_checker
// Watches the request, result and control channels of the console writer,
// keeps its own copy of the screen, cursor and mode registers, and compares
// every result word with the word predicted for the oldest open request.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module text_console_writer_checker #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic                          full,
   input  logic [2:0]                    req_operation,
   input  logic [7:0]                    req_char_code,
   input  logic signed [7:0]             req_col_value,
   input  logic signed [5:0]             req_row_value,
   input  logic                          pop,
   input  logic                          empty,
   input  logic [6:0]                    rsp_cursor_col,
   input  logic [4:0]                    rsp_cursor_row,
   input  logic [7:0]                    rsp_cell_char,
   input  logic [7:0]                    rsp_cell_attr,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [tcw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_wdata,
   output int                            mismatch_count,
   output int                            words_pending,
   output int                            words_checked
);
   import tcw_pkg::*;

   localparam int REPORT_LIMIT = 10;

   // Shadow screen, cursor and mode registers
   logic [15:0] screen_copy [COLS*ROWS];
   int          cur_col;
   int          cur_row;
   logic [7:0]  attr_reg;
   logic        scroll_off_reg;

   // Result words still owed by the block, oldest first
   rsp_type     owed_words [$];
   rsp_type     want_word;
   rsp_type     got_word;

   function automatic int clamp_coord(int v, int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void blank_screen(logic [7:0] attr);
      int i;
      for (i = 0; i < COLS*ROWS; i++) screen_copy[i] = {attr, BLANK_CHAR};
   endfunction

   // Step to the next row; scroll up or wrap to the top past the last one
   function automatic void next_row();
      int i;
      cur_col = 0;
      cur_row++;
      if (cur_row < ROWS) return;
      if (scroll_off_reg) begin
         cur_row = 0;
         return;
      end
      cur_row = ROWS - 1;
      for (i = 0; i < COLS*(ROWS-1); i++) screen_copy[i] = screen_copy[i+COLS];
      for (i = 0; i < COLS; i++) screen_copy[(ROWS-1)*COLS + i] = {attr_reg, BLANK_CHAR};
   endfunction

   // Apply one request to the shadow state and build the word it returns
   function automatic rsp_type console_step(logic [2:0] op, logic [7:0] ch,
                                             logic signed [7:0] cv,
                                             logic signed [5:0] rv);
      rsp_type     w;
      int          col_arg;
      int          row_arg;
      int          i;
      logic [15:0] cell_word;
      w = '0;
      col_arg = cv;
      row_arg = rv;
      case (op)
         OP_PUT: begin
            if (ch == NEWLINE_CODE) begin
               // blank the rest of the row, then drop to the next
               for (i = cur_col; i < COLS; i++)
                  screen_copy[cur_row*COLS + i] = {attr_reg, BLANK_CHAR};
               next_row();
            end else begin
               screen_copy[cur_row*COLS + cur_col] = {attr_reg, ch};
               cur_col++;
               if (cur_col >= COLS) next_row();
            end
         end
         OP_MOVE_ABS: begin
            cur_col = clamp_coord(col_arg, COLS - 1);
            cur_row = clamp_coord(row_arg, ROWS - 1);
         end
         OP_MOVE_REL: begin
            cur_col = clamp_coord(cur_col + col_arg, COLS - 1);
            cur_row = clamp_coord(cur_row + row_arg, ROWS - 1);
         end
         OP_CLEAR: begin
            cur_col = 0;
            cur_row = 0;
            blank_screen(attr_reg);
         end
         OP_READ: begin
            cell_word = screen_copy[clamp_coord(row_arg, ROWS - 1)*COLS +
                                    clamp_coord(col_arg, COLS - 1)];
            w.cell_char = cell_word[7:0];
            w.cell_attr = cell_word[15:8];
         end
         default: ;
      endcase
      w.cursor_col = cur_col[COL_W-1:0];
      w.cursor_row = cur_row[OUT_ROW_W-1:0];
      return w;
   endfunction

   // Track the channels: results first, then mode writes, then new requests
   always @(posedge clock) begin
      if (reset) begin
         blank_screen(RESET_ATTR);
         cur_col        = 0;
         cur_row        = 0;
         attr_reg       = RESET_ATTR;
         scroll_off_reg = 1'b0;
         owed_words.delete();
         mismatch_count = 0;
         words_checked  = 0;
      end else begin
         if (pop && !empty) begin
            got_word.cursor_col = rsp_cursor_col;
            got_word.cursor_row = rsp_cursor_row;
            got_word.cell_char  = rsp_cell_char;
            got_word.cell_attr  = rsp_cell_attr;
            if (owed_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: result word with no open request: col %0d row %0d",
                           $realtime, got_word.cursor_col, got_word.cursor_row);
            end else begin
               want_word = owed_words.pop_front();
               words_checked++;
               if (got_word.cursor_col !== want_word.cursor_col ||
                   got_word.cursor_row !== want_word.cursor_row ||
                   got_word.cell_char  !== want_word.cell_char  ||
                   got_word.cell_attr  !== want_word.cell_attr) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"%0t: word %0d: expected col %0d row %0d char %h attr %h,",
                               " got col %0d row %0d char %h attr %h"},
                              $realtime, words_checked,
                              want_word.cursor_col, want_word.cursor_row,
                              want_word.cell_char, want_word.cell_attr,
                              got_word.cursor_col, got_word.cursor_row,
                              got_word.cell_char, got_word.cell_attr);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TEXT_ATTR:  attr_reg = csr_wdata;
               CSR_SCROLL_OFF: scroll_off_reg = csr_wdata[0];
               default: ;
            endcase
         end
         if (push && !full)
            owed_words.push_back(console_step(req_operation, req_char_code,
                                              req_col_value, req_row_value));
      end
      words_pending = owed_words.size();
   end

endmodule

FILE: bench/text_console_writer_tb.sv
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Drives request words and mode writes into the console writer with random
// gaps on the request and result channels; a side checker predicts and compares every result.
// A directed opener hits the cursor limits, wrap, scroll, newline, clear,
// reads and spare opcodes, then random phases run under several modes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module text_console_writer_tb;
   import tcw_pkg::*;

   localparam int COLS          = 80;
   localparam int ROWS          = 25;
   localparam int MAX_WAIT      = 12;
   localparam int SETTLE_CYCLES = 2*COLS*ROWS + 16;
   localparam int IDLE_LIMIT    = 8*COLS*ROWS + 1000;
   localparam int PHASE_WORDS   = 210;
   localparam int PHASES        = 6;

   // Opcodes the block leaves unused
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_MID   = 3'd6;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 push = 1'b0;
   logic                 full;
   logic [2:0]           req_operation = '0;
   logic [7:0]           req_char_code = '0;
   logic signed [7:0]    req_col_value = '0;
   logic signed [5:0]    req_row_value = '0;
   logic                 pop = 1'b0;
   logic                 empty;
   logic [6:0]           rsp_cursor_col;
   logic [4:0]           rsp_cursor_row;
   logic [7:0]           rsp_cell_char;
   logic [7:0]           rsp_cell_attr;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0]           csr_wdata = '0;

   int mismatch_count;
   int words_pending;
   int words_checked;
   int words_sent = 0;
   int directed_words = 0;
   int mode_count = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;

   text_console_writer #(.COLS(COLS), .ROWS(ROWS)) uut (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_operation(req_operation), .req_char_code(req_char_code),
      .req_col_value(req_col_value), .req_row_value(req_row_value),
      .pop(pop), .empty(empty),
      .rsp_cursor_col(rsp_cursor_col), .rsp_cursor_row(rsp_cursor_row),
      .rsp_cell_char(rsp_cell_char), .rsp_cell_attr(rsp_cell_attr),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   text_console_writer_checker #(.COLS(COLS), .ROWS(ROWS)) screen_check (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_operation(req_operation), .req_char_code(req_char_code),
      .req_col_value(req_col_value), .req_row_value(req_row_value),
      .pop(pop), .empty(empty),
      .rsp_cursor_col(rsp_cursor_col), .rsp_cursor_row(rsp_cursor_row),
      .rsp_cell_char(rsp_cell_char), .rsp_cell_attr(rsp_cell_attr),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count),
      .words_pending(words_pending),
      .words_checked(words_checked)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hold off, then offer one request word until the block takes it
   task automatic send_word(logic [2:0] op, logic [7:0] ch,
                            logic signed [7:0] cv, logic signed [5:0] rv);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push          <= 1'b1;
      req_operation <= op;
      req_char_code <= ch;
      req_col_value <= cv;
      req_row_value <= rv;
      do @(posedge clock); while (full);
      words_sent++;
      @(negedge clock);
   endtask

   // Drop push, drain every owed result and let the engine finish its walk
   task automatic wait_idle();
      push <= 1'b0;
      while (words_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      while (full) @(negedge clock);
   endtask

   // Write both mode registers back to back
   task automatic set_mode(logic [7:0] attr, logic scroll_off);
      csr_valid <= 1'b1;
      csr_index <= CSR_TEXT_ATTR;
      csr_wdata <= attr;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_index <= CSR_SCROLL_OFF;
      csr_wdata <= {7'd0, scroll_off};
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      mode_count++;
   endtask

   function automatic logic signed [7:0] rand_col();
      int v;
      v = $urandom_range(0, 160);
      return 8'(v - 80);
   endfunction

   function automatic logic signed [5:0] rand_row();
      int v;
      v = $urandom_range(0, 50);
      return 6'(v - 25);
   endfunction

   // Mostly random bytes, with newlines and the byte extremes mixed in
   function automatic logic [7:0] pick_char();
      int sel;
      sel = $urandom_range(0, 15);
      if (sel < 2) return NEWLINE_CODE;
      if (sel == 2) return 8'h00;
      if (sel == 3) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // Random sequences until the phase has sent its share of words
   task automatic run_phase(int count);
      int first;
      int sel;
      int c;
      int r;
      int n;
      int k;
      first = words_sent;
      while (words_sent - first < count) begin
         quiet = ($urandom_range(0, 3) == 0);
         sel = $urandom_range(0, 99);
         if (sel < 40) begin
            // place the cursor, type a run, read part of it back
            c = $urandom_range(0, COLS - 1);
            r = $urandom_range(0, ROWS - 1);
            n = $urandom_range(1, 12);
            send_word(OP_MOVE_ABS, 8'($urandom), 8'(c), 6'(r));
            for (k = 0; k < n; k++) send_word(OP_PUT, pick_char(), rand_col(), rand_row());
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) begin
               c = c + $urandom_range(0, 4);
               send_word(OP_READ, 8'($urandom), 8'((c > 80) ? 80 : c), 6'(r));
            end
         end else if (sel < 55) begin
            // type near the bottom right corner to force wraps and overflow
            c = $urandom_range(60, 80);
            r = $urandom_range(ROWS - 1, ROWS);
            n = $urandom_range(3, 25);
            send_word(OP_MOVE_ABS, 8'($urandom), 8'(c), 6'(r));
            for (k = 0; k < n; k++) send_word(OP_PUT, pick_char(), rand_col(), rand_row());
            send_word(OP_READ, 8'($urandom), rand_col(), 6'(ROWS - 2));
         end else if (sel < 70) begin
            send_word(3'($urandom_range(0, 7)), 8'($urandom), rand_col(), rand_row());
         end else if (sel < 82) begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++)
               send_word(OP_MOVE_REL, 8'($urandom), rand_col(), rand_row());
         end else if (sel < 97) begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++)
               send_word(OP_READ, 8'($urandom), rand_col(), rand_row());
         end else begin
            send_word(OP_CLEAR, 8'($urandom), rand_col(), rand_row());
         end
      end
   endtask

   // Result side: random stall before each word, pop until one is taken
   initial begin
      int stall;
      forever begin
         stall = quiet ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         @(negedge clock);
      end
   end

   // Watchdog: end the run if no handshake completes for too long
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d results still owed",
                  $realtime, idle_cycles, words_pending);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Stimulus and verdict
   initial begin
      int p;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      wait_idle();

      // Directed opener under reset modes
      send_word(OP_READ, 8'h00, 0, 0);
      send_word(OP_PUT, 8'h41, 0, 0);
      send_word(OP_PUT, 8'h00, 0, 0);
      send_word(OP_PUT, 8'hFF, 0, 0);
      send_word(OP_READ, 8'h00, 0, 0);
      send_word(OP_READ, 8'h00, 1, 0);
      send_word(OP_READ, 8'h00, 2, 0);
      send_word(OP_MOVE_ABS, 8'h00, -80, -25);
      send_word(OP_MOVE_ABS, 8'hFF, 80, 25);
      send_word(OP_PUT, 8'h5A, 0, 0);
      send_word(OP_READ, 8'h00, 79, 23);
      send_word(OP_READ, 8'h00, -80, -25);
      send_word(OP_READ, 8'h00, 80, 25);
      send_word(OP_MOVE_REL, 8'h00, 80, 25);
      send_word(OP_MOVE_REL, 8'h00, -80, -25);
      send_word(OP_MOVE_REL, 8'h00, 5, -3);
      send_word(OP_MOVE_ABS, 8'h00, 10, 3);
      send_word(OP_PUT, NEWLINE_CODE, 0, 0);
      send_word(OP_READ, 8'h00, 20, 3);
      send_word(OP_SPARE_FIRST, 8'hFF, -1, -1);
      send_word(OP_SPARE_MID, 8'h0A, 80, 25);
      send_word(OP_SPARE_LAST, 8'h55, -80, -25);
      send_word(OP_CLEAR, 8'h00, 0, 0);
      send_word(OP_READ, 8'h00, 40, 12);
      directed_words = words_sent;

      // Random phases, modes changed only with the block idle
      for (p = 0; p < PHASES; p++) begin
         wait_idle();
         case (p)
            0:       set_mode(8'hFF, 1'b1);
            1:       set_mode(8'h00, 1'b0);
            2:       set_mode(RESET_ATTR, 1'b1);
            default: set_mode(8'($urandom), 1'($urandom));
         endcase
         if (p == 0) begin
            // overflow with scrolling off at the bottom right corner
            send_word(OP_MOVE_ABS, 8'h00, 79, 24);
            send_word(OP_PUT, 8'h21, 0, 0);
            send_word(OP_READ, 8'h00, 79, 24);
         end
         run_phase(PHASE_WORDS);
      end
      wait_idle();

      $display("covered %0d request words (%0d directed) over %0d mode settings",
               words_sent, directed_words, mode_count);
      $display("compared %0d result words, %0d mismatches, %0d left unanswered",
               words_checked, mismatch_count, words_pending);
      if (mismatch_count == 0 && words_pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
